FILE: hw/rtl/dpc_pkg.sv
`default_nettype none

package dpc_pkg;

   // result class codes
   typedef enum logic [1:0] {
      CLASS_NONE     = 2'd0,
      CLASS_QUERY    = 2'd1,
      CLASS_RESPONSE = 2'd2
   } dpc_class_type;

   // ip kind codes, same values as the reported version
   localparam logic [2:0] IP_KIND_NONE = 3'd0;
   localparam logic [2:0] IP_KIND_V4   = 3'd4;
   localparam logic [2:0] IP_KIND_V6   = 3'd6;

   localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
   localparam logic [15:0] ETH_TYPE_IPV6  = 16'h86DD;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [15:0] DNS_PORT_RESET = 16'd53;
   localparam logic [15:0] RCODE_MASK     = 16'h000F;

   // byte positions from frame start
   localparam int POS_ETH_TYPE_HI = 12;
   localparam int POS_ETH_TYPE_LO = 13;
   localparam int POS_IPV4_IHL    = 14;
   localparam int POS_IPV6_NH     = 20;
   localparam int POS_IPV4_PROTO  = 23;

   localparam int ETH_HDR_BYTES  = 14;
   localparam int IPV4_MIN_BYTES = 20;
   localparam int IPV6_HDR_BYTES = 40;
   localparam int UDP_HDR_BYTES  = 8;
   localparam int DNS_HDR_BYTES  = 12;

   // byte offsets from the UDP header start
   localparam int OFF_SRC_HI   = 0;
   localparam int OFF_SRC_LO   = 1;
   localparam int OFF_DST_HI   = 2;
   localparam int OFF_DST_LO   = 3;
   localparam int OFF_FLAGS_HI = 10;
   localparam int OFF_FLAGS_LO = 11;

   localparam int DLEN_W  = 10;
   localparam int CNT_W   = 64;

   // event counter slots
   localparam int CNT_QUERY    = 0;
   localparam int CNT_RESPONSE = 1;
   localparam int CNT_ERROR    = 2;
   localparam int CNT_IPV4     = 3;
   localparam int CNT_IPV6     = 4;
   localparam int CNT_NUM      = 5;

endpackage

`default_nettype wire

FILE: hw/rtl/dpc_if.sv
`default_nettype none

interface dpc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_last;

   modport source (output valid, frame_byte, frame_last, input ready);
   modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

interface dpc_rsp_if import dpc_pkg::*;;
   logic                valid;
   logic                ready;
   dpc_class_type       frame_class;
   logic [2:0]          ip_version;
   logic                rcode_error;
   logic [15:0]         source_port;
   logic [15:0]         dest_port;
   logic [DLEN_W-1:0]   dns_length;
   logic [CNT_W-1:0]    query_total;
   logic [CNT_W-1:0]    response_total;
   logic [CNT_W-1:0]    error_total;
   logic [CNT_W-1:0]    ipv4_total;
   logic [CNT_W-1:0]    ipv6_total;

   modport source (output valid, frame_class, ip_version, rcode_error, source_port,
                   dest_port, dns_length, query_total, response_total, error_total,
                   ipv4_total, ipv6_total, input ready);
   modport sink   (input valid, frame_class, ip_version, rcode_error, source_port,
                   dest_port, dns_length, query_total, response_total, error_total,
                   ipv4_total, ipv6_total, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dns_packet_classifier.sv
// A frame's result passes from its last accepted beat through the verdict register to the output register.
// Throughput: one beat per cycle; the parser, the verdict register and the
//   output register each advance every cycle the result side is not stalled.
// Reset (synchronous, active high): parser state and the five event counters
//   clear to zero, dns_port returns to 53, no result is pending.
`default_nettype none

module dns_packet_classifier import dpc_pkg::*; #(
   parameter int MAX_PAYLOAD = 512,
   parameter int MAX_FRAME   = 16384
) (
   input  wire         clock,
   input  wire         reset,
   dpc_req_if.sink     req_bus,
   dpc_rsp_if.source   rsp_bus,
   input  wire         csr_wr_en,
   input  wire [15:0]  csr_wr_data
);

   // byte position counts up to MAX_FRAME and sticks there
   localparam int POS_W = $clog2(MAX_FRAME + 1);
   localparam int PL_W  = $clog2(MAX_PAYLOAD + 1);
   // compare width: covers position, payload limit and header offsets
   localparam int CW0   = (POS_W > PL_W) ? POS_W : PL_W;
   localparam int CW    = ((CW0 > 7) ? CW0 : 7) + 1;

   // ---------------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------------
   logic [15:0] dns_port_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dns_port_ff <= DNS_PORT_RESET;
      end else if (csr_wr_en) begin
         dns_port_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------------
   // Frame parser state (cleared after every last beat)
   // ---------------------------------------------------------------------
   logic [POS_W-1:0] pos_ff,      pos_in;
   logic [7:0]       eth_hi_ff,   eth_hi_in;
   logic [2:0]       kind_ff,     kind_in;
   logic [5:0]       ihb_ff,      ihb_in;
   logic [7:0]       proto_ff,    proto_in;
   logic [15:0]      src_ff,      src_in;
   logic [15:0]      dst_ff,      dst_in;
   logic [15:0]      flags_ff,    flags_in;

   // verdict register: one per finished frame
   logic             vrd_vld_ff,  vrd_vld_in;
   dpc_class_type    vrd_cls_ff,  vrd_cls_in;
   logic [2:0]       vrd_ver_ff,  vrd_ver_in;
   logic             vrd_err_ff,  vrd_err_in;
   logic [15:0]      vrd_src_ff,  vrd_src_in;
   logic [15:0]      vrd_dst_ff,  vrd_dst_in;
   logic [DLEN_W-1:0] vrd_dlen_ff, vrd_dlen_in;

   logic             in_accept;
   logic             out_adv;
   logic             room;
   logic [7:0]       b;
   logic [15:0]      eth_type;
   logic [CW-1:0]    pos_x;
   logic [CW-1:0]    hdr_base;
   logic [CW-1:0]    udp_off;
   logic [CW-1:0]    frame_len;
   logic [CW-1:0]    udp_end;
   logic [CW-1:0]    pay_len;
   logic [CW+DLEN_W-1:0] pay_ext;
   logic             ok;
   logic             is_resp;
   logic             is_err;

   assign b         = req_bus.frame_byte;
   assign in_accept = req_bus.valid && req_bus.ready;

   // output slot is free or being emptied this cycle
   assign out_adv       = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = !vrd_vld_ff || out_adv;

   assign room     = pos_ff < POS_W'(MAX_FRAME);
   assign pos_x    = {{(CW-POS_W){1'b0}}, pos_ff};
   assign eth_type = {eth_hi_ff, b};

   always_comb begin
      pos_in     = pos_ff;
      eth_hi_in  = eth_hi_ff;
      kind_in    = kind_ff;
      ihb_in     = ihb_ff;
      proto_in   = proto_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      flags_in   = flags_ff;
      hdr_base   = CW'(ETH_HDR_BYTES) + {{(CW-6){1'b0}}, ihb_ff};
      udp_off    = '0;

      if (room) begin
         if (pos_ff == POS_W'(POS_ETH_TYPE_HI)) begin
            eth_hi_in = b;
         end
         // EtherType decode; the new kind applies to this same beat
         if (pos_ff == POS_W'(POS_ETH_TYPE_LO)) begin
            if (eth_type == ETH_TYPE_IPV4) begin
               kind_in = IP_KIND_V4;
            end else if (eth_type == ETH_TYPE_IPV6) begin
               kind_in = IP_KIND_V6;
               ihb_in  = 6'(IPV6_HDR_BYTES);
            end else begin
               kind_in = IP_KIND_NONE;
            end
         end
         if (kind_in == IP_KIND_V4 && pos_ff == POS_W'(POS_IPV4_IHL)) begin
            ihb_in = {b[3:0], 2'b00};
         end
         if ((kind_in == IP_KIND_V4 && pos_ff == POS_W'(POS_IPV4_PROTO)) ||
             (kind_in == IP_KIND_V6 && pos_ff == POS_W'(POS_IPV6_NH))) begin
            proto_in = b;
         end
         // UDP / DNS header capture; a short IHL may overlap the IPv4 header
         hdr_base = CW'(ETH_HDR_BYTES) + {{(CW-6){1'b0}}, ihb_in};
         udp_off  = pos_x - hdr_base;
         if (kind_in != IP_KIND_NONE && pos_x >= hdr_base) begin
            if (udp_off == CW'(OFF_SRC_HI))   src_in[15:8]   = b;
            if (udp_off == CW'(OFF_SRC_LO))   src_in[7:0]    = b;
            if (udp_off == CW'(OFF_DST_HI))   dst_in[15:8]   = b;
            if (udp_off == CW'(OFF_DST_LO))   dst_in[7:0]    = b;
            if (udp_off == CW'(OFF_FLAGS_HI)) flags_in[15:8] = b;
            if (udp_off == CW'(OFF_FLAGS_LO)) flags_in[7:0]  = b;
         end
         pos_in = pos_ff + 1'b1;
      end
   end

   // frame verdict, from the state after this beat
   always_comb begin
      frame_len = {{(CW-POS_W){1'b0}}, pos_in};
      udp_end   = CW'(ETH_HDR_BYTES + UDP_HDR_BYTES) + {{(CW-6){1'b0}}, ihb_in};
      ok        = 1'b0;
      if (kind_in == IP_KIND_V4) begin
         ok = frame_len >= CW'(ETH_HDR_BYTES + IPV4_MIN_BYTES + UDP_HDR_BYTES - 8);
      end else if (kind_in == IP_KIND_V6) begin
         ok = frame_len >= CW'(ETH_HDR_BYTES + IPV6_HDR_BYTES);
      end
      ok = ok && proto_in == PROTO_UDP && frame_len >= udp_end;
      ok = ok && (src_in == dns_port_ff || dst_in == dns_port_ff);
      ok = ok && frame_len >= udp_end + CW'(DNS_HDR_BYTES);

      is_resp = flags_in[15];
      is_err  = (flags_in & RCODE_MASK) != 16'd0;
      pay_len = frame_len - udp_end;
      if (pay_len > CW'(MAX_PAYLOAD)) begin
         pay_len = CW'(MAX_PAYLOAD);
      end
      pay_ext = {{DLEN_W{1'b0}}, pay_len};

      vrd_src_in = src_in;
      vrd_dst_in = dst_in;
      if (ok) begin
         vrd_cls_in  = is_resp ? CLASS_RESPONSE : CLASS_QUERY;
         vrd_ver_in  = kind_in;
         vrd_err_in  = is_err;
         vrd_dlen_in = pay_ext[DLEN_W-1:0];
      end else begin
         vrd_cls_in  = CLASS_NONE;
         vrd_ver_in  = IP_KIND_NONE;
         vrd_err_in  = 1'b0;
         vrd_dlen_in = '0;
      end
   end

   assign vrd_vld_in = in_accept && req_bus.frame_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         eth_hi_ff <= '0;
         kind_ff   <= IP_KIND_NONE;
         ihb_ff    <= '0;
         proto_ff  <= '0;
         src_ff    <= '0;
         dst_ff    <= '0;
         flags_ff  <= '0;
      end else if (in_accept) begin
         if (req_bus.frame_last) begin
            // frame done: back to a clean parser
            pos_ff    <= '0;
            eth_hi_ff <= '0;
            kind_ff   <= IP_KIND_NONE;
            ihb_ff    <= '0;
            proto_ff  <= '0;
            src_ff    <= '0;
            dst_ff    <= '0;
            flags_ff  <= '0;
         end else begin
            pos_ff    <= pos_in;
            eth_hi_ff <= eth_hi_in;
            kind_ff   <= kind_in;
            ihb_ff    <= ihb_in;
            proto_ff  <= proto_in;
            src_ff    <= src_in;
            dst_ff    <= dst_in;
            flags_ff  <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vrd_vld_ff <= 1'b0;
      end else if (req_bus.ready) begin
         vrd_vld_ff <= vrd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && vrd_vld_in) begin
         vrd_cls_ff  <= vrd_cls_in;
         vrd_ver_ff  <= vrd_ver_in;
         vrd_err_ff  <= vrd_err_in;
         vrd_src_ff  <= vrd_src_in;
         vrd_dst_ff  <= vrd_dst_in;
         vrd_dlen_ff <= vrd_dlen_in;
      end
   end

   // ---------------------------------------------------------------------
   // Event counters and output register
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0] cnt_ff [CNT_NUM];
   logic [CNT_W-1:0] cnt_in [CNT_NUM];
   logic             cnt_load;
   logic             rsp_vld_ff, rsp_vld_in;

   assign cnt_load = vrd_vld_ff && out_adv;

   always_comb begin
      cnt_in[CNT_QUERY]    = cnt_ff[CNT_QUERY]
                           + CNT_W'(vrd_cls_ff == CLASS_QUERY);
      cnt_in[CNT_RESPONSE] = cnt_ff[CNT_RESPONSE]
                           + CNT_W'(vrd_cls_ff == CLASS_RESPONSE);
      cnt_in[CNT_ERROR]    = cnt_ff[CNT_ERROR] + CNT_W'(vrd_err_ff);
      cnt_in[CNT_IPV4]     = cnt_ff[CNT_IPV4] + CNT_W'(vrd_ver_ff == IP_KIND_V4);
      cnt_in[CNT_IPV6]     = cnt_ff[CNT_IPV6] + CNT_W'(vrd_ver_ff == IP_KIND_V6);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CNT_NUM; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (cnt_load) begin
         for (int i = 0; i < CNT_NUM; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   assign rsp_vld_in = out_adv ? vrd_vld_ff : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_load) begin
         rsp_bus.frame_class    <= vrd_cls_ff;
         rsp_bus.ip_version     <= vrd_ver_ff;
         rsp_bus.rcode_error    <= vrd_err_ff;
         rsp_bus.source_port    <= vrd_src_ff;
         rsp_bus.dest_port      <= vrd_dst_ff;
         rsp_bus.dns_length     <= vrd_dlen_ff;
         rsp_bus.query_total    <= cnt_in[CNT_QUERY];
         rsp_bus.response_total <= cnt_in[CNT_RESPONSE];
         rsp_bus.error_total    <= cnt_in[CNT_ERROR];
         rsp_bus.ipv4_total     <= cnt_in[CNT_IPV4];
         rsp_bus.ipv6_total     <= cnt_in[CNT_IPV6];
      end
   end

   assign rsp_bus.valid = rsp_vld_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/dpc_checker.sv
`default_nettype none

module dpc_checker import dpc_pkg::*; (
   input wire               clock,
   input wire               reset,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input wire [1:0]         rsp_class,
   input wire [2:0]         rsp_version,
   input wire               rsp_error,
   input wire [DLEN_W-1:0]  rsp_length,
   input wire [CNT_W-1:0]   rsp_query_total
);

   // nothing pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result stays valid and holds its query total
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_query_total))
      else $error("stalled result changed");

   // a non-DNS frame reports no version, error or length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_class == CLASS_NONE |->
         rsp_version == IP_KIND_NONE && !rsp_error && rsp_length == '0)
      else $error("non-DNS frame carries DNS fields");

   // a DNS frame is IPv4 or IPv6
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_class != CLASS_NONE |->
         rsp_version == IP_KIND_V4 || rsp_version == IP_KIND_V6)
      else $error("DNS frame without IP version");

endmodule

bind dns_packet_classifier dpc_checker u_dpc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_class       (rsp_bus.frame_class),
   .rsp_version     (rsp_bus.ip_version),
   .rsp_error       (rsp_bus.rcode_error),
   .rsp_length      (rsp_bus.dns_length),
   .rsp_query_total (rsp_bus.query_total)
);

`default_nettype wire
